### rtl/heightmap_triangle_height_sampler_core_defines.svh
// Assertion macros for the heightmap triangle height sampler.
// Used by the top level; expects clk and arst_n in scope.
`ifndef HEIGHTMAP_TRIANGLE_HEIGHT_SAMPLER_CORE_DEFINES_SVH
`define HEIGHTMAP_TRIANGLE_HEIGHT_SAMPLER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define HTS_ASSERT(lbl, ante, cons) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (ante) |-> (cons)) else $error("hts check failed");
`define HTS_ASSERT_NEXT(lbl, ante, cons) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (ante) |=> (cons)) else $error("hts check failed");
`else
`define HTS_ASSERT(lbl, ante, cons)
`define HTS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/hts_pkg.sv
// Shared types and constants for the heightmap triangle height sampler.
// No dependencies.
package hts_pkg;
	localparam int MAX_COLUMNS = 256;
	localparam int MAX_ROWS = 256;
	localparam int POS_FRAC = 8;
	localparam int STORE_SIZE = MAX_COLUMNS * MAX_ROWS;
	localparam int ADDR_W = $clog2(STORE_SIZE);
	localparam int COL_W = $clog2(MAX_COLUMNS);
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int POS_W = 24;
	localparam int HGT_W = 16;
	localparam int DIM_W = 9;
	localparam int IDX_W = 16;
	localparam int PROD_W = HGT_W + 1 + POS_FRAC + 1;
	localparam int SUM_W = PROD_W + 2;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [1:0] CFG_GRID_WIDTH = 2'd0;
	localparam logic [1:0] CFG_GRID_DEPTH = 2'd1;
	localparam logic [1:0] CFG_ORIGIN_X = 2'd2;
	localparam logic [1:0] CFG_ORIGIN_Z = 2'd3;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic cmd;
		logic [IDX_W-1:0] vertex_index;
		logic signed [HGT_W-1:0] vertex_height;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_z;
	} item_t;

	typedef struct packed {
		logic signed [HGT_W-1:0] height;
		logic in_range;
	} result_t;

	// clamped grid size and origin; the user must keep them stable while items are in flight (not enforced)
	typedef struct packed {
		logic [DIM_W-1:0] gw;
		logic [DIM_W-1:0] gd;
		logic signed [POS_W-1:0] origin_x;
		logic signed [POS_W-1:0] origin_z;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic is_query;
		logic ok;
		logic [ADDR_W-1:0] addr;
		logic signed [HGT_W-1:0] wdata;
		logic [POS_FRAC-1:0] fx;
		logic [POS_FRAC-1:0] fz;
	} entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;
endpackage

### rtl/hts_front.sv
// Front end: accepts items, checks the range, computes the cell base address.
// Depends on hts_pkg.
module hts_front (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input hts_pkg::item_t item,
	input hts_pkg::cfg_t cfg,
	input logic q_full,
	output logic push,
	output hts_pkg::entry_t entry
);
	localparam int LW = hts_pkg::POS_W + 1;
	localparam int CFW = hts_pkg::POS_W - hts_pkg::POS_FRAC;

	logic signed [LW-1:0] lx, lz;
	logic [CFW-1:0] cx_full, cz_full;
	logic ok_x, ok_z, load_ok, accept;

	logic valid_s1;
	logic is_query_s1, ok_s1;
	logic [hts_pkg::COL_W-1:0] cx_s1;
	logic [hts_pkg::ROW_W-1:0] cz_s1;
	logic [hts_pkg::POS_FRAC-1:0] fx_s1, fz_s1;
	logic [hts_pkg::ADDR_W-1:0] idx_s1;
	logic signed [hts_pkg::HGT_W-1:0] wdata_s1;
	logic [hts_pkg::ADDR_W:0] base;

	assign lx = LW'(item.pos_x) - LW'(cfg.origin_x);
	assign lz = LW'(item.pos_z) - LW'(cfg.origin_z);
	assign cx_full = lx[hts_pkg::POS_W-1:hts_pkg::POS_FRAC];
	assign cz_full = lz[hts_pkg::POS_W-1:hts_pkg::POS_FRAC];
	// cell must leave room for the far corner
	assign ok_x = !lx[LW-1] && ((CFW+1)'(cx_full) + (CFW+1)'(1) < (CFW+1)'(cfg.gw));
	assign ok_z = !lz[LW-1] && ((CFW+1)'(cz_full) + (CFW+1)'(1) < (CFW+1)'(cfg.gd));
	assign load_ok = 32'(item.vertex_index) < hts_pkg::STORE_SIZE;

	assign busy = valid_s1 && q_full;
	assign accept = start && !busy;
	assign push = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_query_s1 <= (item.cmd == hts_pkg::CMD_QUERY);
			ok_s1 <= (item.cmd == hts_pkg::CMD_QUERY) ? (ok_x && ok_z) : load_ok;
			cx_s1 <= cx_full[hts_pkg::COL_W-1:0];
			cz_s1 <= cz_full[hts_pkg::ROW_W-1:0];
			fx_s1 <= lx[hts_pkg::POS_FRAC-1:0];
			fz_s1 <= lz[hts_pkg::POS_FRAC-1:0];
			idx_s1 <= item.vertex_index[hts_pkg::ADDR_W-1:0];
			wdata_s1 <= item.vertex_height;
		end
	end

	assign base = (hts_pkg::ADDR_W+1)'(cz_s1 * cfg.gw) + (hts_pkg::ADDR_W+1)'(cx_s1);

	always_comb begin
		entry.is_query = is_query_s1;
		entry.ok = ok_s1;
		entry.addr = is_query_s1 ? base[hts_pkg::ADDR_W-1:0] : idx_s1;
		entry.wdata = wdata_s1;
		entry.fx = fx_s1;
		entry.fz = fz_s1;
	end
endmodule

### rtl/hts_queue.sv
// Short queue of classified items between front and back end.
// Depends on hts_pkg.
module hts_queue (
	input logic clk,
	input logic arst_n,
	input hts_pkg::q_ctrl_t ctrl,
	output hts_pkg::q_stat_t stat,
	input hts_pkg::entry_t wr_entry,
	output hts_pkg::entry_t rd_entry
);
	hts_pkg::entry_t slots_q [hts_pkg::QDEPTH];
	logic [hts_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [hts_pkg::QPTR_W:0] count_q;
	logic do_push, do_pop;

	assign stat.full = (count_q == (hts_pkg::QPTR_W+1)'(hts_pkg::QDEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push = ctrl.push && !stat.full;
	assign do_pop = ctrl.pop && !stat.empty;
	assign rd_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slots_q[wr_ptr_q] <= wr_entry;
	end
endmodule

### rtl/hts_back.sv
// Back end: height store, corner reads and triangle interpolation.
// Depends on hts_pkg.
module hts_back (
	input logic clk,
	input logic arst_n,
	input hts_pkg::cfg_t cfg,
	input hts_pkg::q_stat_t q_stat,
	output logic pop,
	input hts_pkg::entry_t head,
	output logic done,
	output hts_pkg::result_t result
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD_LO = 5'b00010,
		S_RD_HI = 5'b00100,
		S_MUL = 5'b01000,
		S_SUM = 5'b10000
	} state_t;

	localparam int AW = hts_pkg::ADDR_W;
	localparam int HW = hts_pkg::HGT_W;
	localparam int F = hts_pkg::POS_FRAC;
	localparam int PW = hts_pkg::PROD_W;
	localparam int SW = hts_pkg::SUM_W;

	state_t state_q;
	logic signed [HW-1:0] mem [hts_pkg::STORE_SIZE];
	logic signed [HW-1:0] rd_a_q, rd_b_q, h00_q, h10_q;
	logic [AW-1:0] base_q, rd_addr_a, rd_addr_b;
	logic [F-1:0] fx_q, fz_q;
	logic signed [PW-1:0] p1_q, p2_q, p1_d, p2_d;
	logic signed [HW:0] d1, d2;
	logic signed [F:0] w1, w2;
	logic signed [SW-1:0] sum, shifted;
	logic signed [SW-1:0] h_full;
	logic signed [HW-1:0] h_sat;
	logic done_q;
	hts_pkg::result_t result_q;

	assign pop = (state_q == S_IDLE) && !q_stat.empty;

	// low pair: base, base+1; high pair: one row up
	always_comb begin
		rd_addr_a = base_q;
		if (state_q == S_RD_HI) rd_addr_a = AW'(base_q + AW'(cfg.gw));
		rd_addr_b = AW'(rd_addr_a + 1'b1);
	end

	always_ff @(posedge clk) begin
		if (pop && !head.is_query && head.ok) mem[head.addr] <= head.wdata;
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
	end

	// pick the triangle; rd_a_q/rd_b_q hold h01/h11 in S_MUL
	always_comb begin
		if (fx_q > fz_q) begin
			d1 = (HW+1)'(h10_q) - (HW+1)'(h00_q);
			d2 = (HW+1)'(rd_b_q) - (HW+1)'(h10_q);
			w1 = $signed({1'b0, fx_q});
			w2 = $signed({1'b0, fz_q});
		end else begin
			d1 = (HW+1)'(rd_a_q) - (HW+1)'(h00_q);
			d2 = (HW+1)'(rd_b_q) - (HW+1)'(rd_a_q);
			w1 = $signed({1'b0, fz_q});
			w2 = $signed({1'b0, fx_q});
		end
		p1_d = d1 * w1;
		p2_d = d2 * w2;
	end

	// round to nearest, halves up, then saturate
	always_comb begin
		sum = SW'(p1_q) + SW'(p2_q) + SW'(1 << (F - 1));
		shifted = sum >>> F;
		h_full = shifted + SW'(h00_q);
		if (h_full > SW'(32767)) begin
			h_sat = 16'sh7fff;
		end else if (h_full < -SW'(32768)) begin
			h_sat = -16'sh8000;
		end else begin
			h_sat = h_full[HW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop && head.is_query) begin
						if (head.ok) begin
							state_q <= S_RD_LO;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_RD_LO: state_q <= S_RD_HI;
				S_RD_HI: state_q <= S_MUL;
				S_MUL: state_q <= S_SUM;
				S_SUM: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				base_q <= head.addr;
				fx_q <= head.fx;
				fz_q <= head.fz;
				result_q.height <= '0;
				result_q.in_range <= 1'b0;
			end
			S_RD_HI: begin
				h00_q <= rd_a_q;
				h10_q <= rd_b_q;
			end
			S_MUL: begin
				p1_q <= p1_d;
				p2_q <= p2_d;
			end
			S_SUM: begin
				result_q.height <= h_sat;
				result_q.in_range <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign result = result_q;
endmodule

### rtl/heightmap_triangle_height_sampler_core.sv
// Heightmap triangle height sampler, top level.
// A query inside the grid is registered in the front end and queued; the back end
// then does two dual-port reads of the store, a multiply and a round.
// Loads and outside queries are done in the back end's idle state; a 4-entry queue buffers.
// Reset clears control state and sets the grid to 256 x 256 at origin 0;
// the height store is not cleared.
`include "heightmap_triangle_height_sampler_core_defines.svh"
module heightmap_triangle_height_sampler_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input hts_pkg::item_t item,
	output logic done,
	output hts_pkg::result_t result,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [hts_pkg::POS_W-1:0] cfg_wdata
);
	logic [hts_pkg::DIM_W-1:0] grid_width_q, grid_depth_q;
	logic signed [hts_pkg::POS_W-1:0] origin_x_q, origin_z_q;
	hts_pkg::cfg_t cfg;
	hts_pkg::q_ctrl_t q_ctrl;
	hts_pkg::q_stat_t q_stat;
	hts_pkg::entry_t push_entry, head;
	logic push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= hts_pkg::DIM_W'(256);
			grid_depth_q <= hts_pkg::DIM_W'(256);
			origin_x_q <= '0;
			origin_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				hts_pkg::CFG_GRID_WIDTH: grid_width_q <= cfg_wdata[hts_pkg::DIM_W-1:0];
				hts_pkg::CFG_GRID_DEPTH: grid_depth_q <= cfg_wdata[hts_pkg::DIM_W-1:0];
				hts_pkg::CFG_ORIGIN_X: origin_x_q <= cfg_wdata;
				hts_pkg::CFG_ORIGIN_Z: origin_z_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// clamp the grid to the store
	always_comb begin
		cfg.gw = (32'(grid_width_q) > hts_pkg::MAX_COLUMNS) ?
			hts_pkg::DIM_W'(hts_pkg::MAX_COLUMNS) : grid_width_q;
		cfg.gd = (32'(grid_depth_q) > hts_pkg::MAX_ROWS) ?
			hts_pkg::DIM_W'(hts_pkg::MAX_ROWS) : grid_depth_q;
		cfg.origin_x = origin_x_q;
		cfg.origin_z = origin_z_q;
	end

	hts_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.cfg(cfg),
		.q_full(q_stat.full),
		.push(push),
		.entry(push_entry)
	);

	assign q_ctrl.push = push;
	assign q_ctrl.pop = pop;

	hts_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(q_ctrl),
		.stat(q_stat),
		.wr_entry(push_entry),
		.rd_entry(head)
	);

	hts_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.q_stat(q_stat),
		.pop(pop),
		.head(head),
		.done(done),
		.result(result)
	);

	`HTS_ASSERT(a_busy_needs_full, busy, q_stat.full)
	`HTS_ASSERT(a_no_push_when_full, push, !q_stat.full)
	`HTS_ASSERT(a_outside_is_zero, done && !result.in_range, result.height == '0)
	`HTS_ASSERT_NEXT(a_pop_needs_data, pop, !$past(q_stat.empty))
endmodule

### bench/heightmap_height_checker.sv
// Checker for the heightmap triangle height sampler: watches the item, result and
// register channels, keeps its own grid and height store, and predicts each query.
// Depends on hts_pkg.
module heightmap_height_checker
	import hts_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input item_t item,
	input logic done,
	input result_t result,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [POS_W-1:0] cfg_wdata,
	output int fails,
	output int outstanding
);
	localparam int REPORT_LIMIT = 10;

	logic [DIM_W-1:0] grid_w;
	logic [DIM_W-1:0] grid_d;
	logic signed [POS_W-1:0] org_x;
	logic signed [POS_W-1:0] org_z;
	logic signed [HGT_W-1:0] heights [0:STORE_SIZE-1];
	result_t due_heights [$];

	function automatic result_t sample_height(logic signed [POS_W-1:0] px,
			logic signed [POS_W-1:0] pz);
		int gw, gd, lx, lz, cx, cz, fx, fz, base;
		longint h00, h10, h01, h11, num, h;
		result_t r;
		r = '0;
		gw = (grid_w > MAX_COLUMNS) ? MAX_COLUMNS : int'(grid_w);
		gd = (grid_d > MAX_ROWS) ? MAX_ROWS : int'(grid_d);
		lx = int'(px) - int'(org_x);
		lz = int'(pz) - int'(org_z);
		if (lx < 0 || lz < 0)
			return r;
		cx = lx >>> POS_FRAC;
		cz = lz >>> POS_FRAC;
		if (cx >= gw - 1 || cz >= gd - 1)
			return r;
		fx = lx & ((1 << POS_FRAC) - 1);
		fz = lz & ((1 << POS_FRAC) - 1);
		base = cz * gw + cx;
		h00 = heights[base];
		h10 = heights[base + 1];
		h01 = heights[base + gw];
		h11 = heights[base + gw + 1];
		// pick the triangle on either side of the cell diagonal
		if (fx > fz)
			num = fx * (h10 - h00) + fz * (h11 - h10);
		else
			num = fz * (h01 - h00) + fx * (h11 - h01);
		// round to nearest, halves toward plus infinity
		h = h00 + ((num + (longint'(1) << (POS_FRAC - 1))) >>> POS_FRAC);
		if (h > 32767)
			h = 32767;
		if (h < -32768)
			h = -32768;
		r.height = h[HGT_W-1:0];
		r.in_range = 1'b1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			grid_w = 9'd256;
			grid_d = 9'd256;
			org_x = '0;
			org_z = '0;
			due_heights.delete();
			outstanding = 0;
			fails = 0;
		end else begin
			if (done) begin
				if (due_heights.size() == 0) begin
					fails++;
					if (fails <= REPORT_LIMIT)
						$display("result with no query waiting: height %0d in_range %0b",
							result.height, result.in_range);
				end else begin
					want = due_heights.pop_front();
					if (result.height !== want.height || result.in_range !== want.in_range) begin
						fails++;
						if (fails <= REPORT_LIMIT)
							$display("height result differs: expected %0d/%0b, got %0d/%0b",
								want.height, want.in_range, result.height, result.in_range);
					end
				end
			end
			if (start && !busy) begin
				if (item.cmd == CMD_LOAD)
					heights[item.vertex_index] = item.vertex_height;
				else
					due_heights.push_back(sample_height(item.pos_x, item.pos_z));
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_GRID_WIDTH: grid_w = cfg_wdata[DIM_W-1:0];
					CFG_GRID_DEPTH: grid_d = cfg_wdata[DIM_W-1:0];
					CFG_ORIGIN_X: org_x = cfg_wdata;
					CFG_ORIGIN_Z: org_z = cfg_wdata;
					default: ;
				endcase
			end
			outstanding = due_heights.size();
		end
	end
endmodule

### bench/tb_heightmap_triangle_height_sampler_core.sv
// Testbench top for heightmap_triangle_height_sampler_core: drives loads, queries and
// grid settings, and gives the verdict from the failure count of the checker.
// Depends on hts_pkg, the core and heightmap_height_checker.
module tb_heightmap_triangle_height_sampler_core;
	import hts_pkg::*;

	localparam int DRAIN_CYCLES = 32;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int FRAC_ONE = 1 << POS_FRAC;

	typedef logic signed [POS_W-1:0] pos_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	item_t cur_item = '0;
	logic done;
	result_t res;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_GRID_WIDTH;
	logic [POS_W-1:0] cfg_wdata = '0;

	int fails;
	int outstanding;
	logic took;
	int quiet_cycles;

	// stimulus-side copy of the grid settings, used only to aim queries and load their corners
	int cfg_w = 256;
	int cfg_d = 256;
	int cfg_ox = 0;
	int cfg_oz = 0;
	bit loaded [int];
	int last_base = 0;
	int sent = 0;
	int burst_left = 0;

	always #6 clk = ~clk;

	heightmap_triangle_height_sampler_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(cur_item),
		.done(done),
		.result(res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	heightmap_height_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(cur_item),
		.done(done),
		.result(res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.fails(fails),
		.outstanding(outstanding)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			took <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			took <= start && !busy;
			quiet_cycles <= ((start && !busy) || done) ? 0 : quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("heightmap_triangle_height_sampler_core: mismatch");
		$finish;
	end

	function automatic int dim_clamp(int v, int top);
		return (v > top) ? top : v;
	endfunction

	// flat store index of the cell's low corner, or -1 when the position is outside
	function automatic int cell_at(pos_t px, pos_t pz);
		int gw, gd, lx, lz;
		gw = dim_clamp(cfg_w, MAX_COLUMNS);
		gd = dim_clamp(cfg_d, MAX_ROWS);
		lx = int'(px) - cfg_ox;
		lz = int'(pz) - cfg_oz;
		if (lx < 0 || lz < 0 || (lx >>> POS_FRAC) >= gw - 1 || (lz >>> POS_FRAC) >= gd - 1)
			return -1;
		return (lz >>> POS_FRAC) * gw + (lx >>> POS_FRAC);
	endfunction

	function automatic logic signed [HGT_W-1:0] rand_height();
		case ($urandom_range(0, 7))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return HGT_W'(int'($urandom_range(0, 64)) - 32);
			default: return HGT_W'($urandom);
		endcase
	endfunction

	function automatic int pick_frac();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return FRAC_ONE - 1;
			default: return $urandom_range(0, FRAC_ONE - 1);
		endcase
	endfunction

	// offset from the origin near the border of a grid with gw vertices
	function automatic int edge_offset(int gw);
		case ($urandom_range(0, 3))
			0: return 0 - int'($urandom_range(1, 300));
			1: return (gw - 1) * FRAC_ONE + int'($urandom_range(0, FRAC_ONE - 1));
			2: return (gw - 2) * FRAC_ONE + FRAC_ONE - 1;
			default: return $urandom_range(0, 4 * FRAC_ONE);
		endcase
	endfunction

	// hold start low for a random gap when the current burst runs out
	task automatic pace();
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(10, 30) : $urandom_range(1, 4))
				@(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	task automatic issue(item_t it);
		pace();
		cur_item <= it;
		start <= 1'b1;
		do
			@(negedge clk);
		while (!took);
		sent++;
	endtask

	task automatic put_height(int idx, logic signed [HGT_W-1:0] h);
		item_t it;
		it.cmd = CMD_LOAD;
		it.vertex_index = IDX_W'(idx);
		it.vertex_height = h;
		it.pos_x = POS_W'($urandom);
		it.pos_z = POS_W'($urandom);
		issue(it);
		loaded[idx] = 1'b1;
	endtask

	// load any corner of the target cell that was never written, then query
	task automatic send_query(pos_t px, pos_t pz);
		int base, gw;
		item_t it;
		base = cell_at(px, pz);
		gw = dim_clamp(cfg_w, MAX_COLUMNS);
		if (base >= 0) begin
			last_base = base;
			if (!loaded.exists(base))
				put_height(base, rand_height());
			if (!loaded.exists(base + 1))
				put_height(base + 1, rand_height());
			if (!loaded.exists(base + gw))
				put_height(base + gw, rand_height());
			if (!loaded.exists(base + gw + 1))
				put_height(base + gw + 1, rand_height());
		end
		it.cmd = CMD_QUERY;
		it.vertex_index = IDX_W'($urandom);
		it.vertex_height = HGT_W'($urandom);
		it.pos_x = px;
		it.pos_z = pz;
		issue(it);
	endtask

	task automatic aim_query();
		int gw, gd, cx, cz, fx, fz;
		gw = dim_clamp(cfg_w, MAX_COLUMNS);
		gd = dim_clamp(cfg_d, MAX_ROWS);
		if (gw < 2 || gd < 2) begin
			send_query(pos_t'(cfg_ox + int'($urandom_range(0, 1023))),
				pos_t'(cfg_oz + int'($urandom_range(0, 1023))));
			return;
		end
		// favor a few low cells so their corners get reused
		cx = ($urandom_range(0, 2) == 0) ? $urandom_range(0, gw - 2)
			: $urandom_range(0, (gw - 2 < 3) ? gw - 2 : 3);
		cz = ($urandom_range(0, 2) == 0) ? $urandom_range(0, gd - 2)
			: $urandom_range(0, (gd - 2 < 3) ? gd - 2 : 3);
		fx = pick_frac();
		fz = ($urandom_range(0, 4) == 0) ? fx : pick_frac();
		send_query(pos_t'(cfg_ox + cx * FRAC_ONE + fx), pos_t'(cfg_oz + cz * FRAC_ONE + fz));
	endtask

	task automatic random_items(int budget);
		int stop_at;
		stop_at = sent + budget;
		while (sent < stop_at) begin
			case ($urandom_range(0, 19))
				0, 1, 2:
					send_query(pos_t'($urandom), pos_t'($urandom));
				3, 4:
					send_query(pos_t'(cfg_ox + edge_offset(dim_clamp(cfg_w, MAX_COLUMNS))),
						pos_t'(cfg_oz + edge_offset(dim_clamp(cfg_d, MAX_ROWS))));
				5:
					put_height($urandom_range(0, STORE_SIZE - 1), rand_height());
				6:
					put_height(last_base + $urandom_range(0, 1), rand_height());
				default:
					aim_query();
			endcase
		end
	endtask

	// wait out all results and any loads still in the pipe
	task automatic drain();
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_grid(int w, int d, int ox, int oz);
		cfg_we <= 1'b1;
		cfg_index <= CFG_GRID_WIDTH;
		cfg_wdata <= POS_W'(w);
		@(negedge clk);
		cfg_index <= CFG_GRID_DEPTH;
		cfg_wdata <= POS_W'(d);
		@(negedge clk);
		cfg_index <= CFG_ORIGIN_X;
		cfg_wdata <= POS_W'(ox);
		@(negedge clk);
		cfg_index <= CFG_ORIGIN_Z;
		cfg_wdata <= POS_W'(oz);
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_w = w & ((1 << DIM_W) - 1);
		cfg_d = d & ((1 << DIM_W) - 1);
		cfg_ox = ox;
		cfg_oz = oz;
	endtask

	task automatic run_phase(int w, int d, int ox, int oz, int budget);
		drain();
		write_grid(w, d, ox, oz);
		random_items(budget);
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset grid of 256 x 256 at origin 0, extreme corner heights
		put_height(0, -16'sd32768);
		put_height(1, 16'sd32767);
		put_height(FRAC_ONE, 16'sd32767);
		put_height(FRAC_ONE + 1, -16'sd32768);
		send_query(0, 0);
		send_query(255, 0);
		send_query(0, 255);
		send_query(128, 128);
		send_query(255, 255);
		send_query(255, 254);
		send_query(1, 0);
		send_query(-1, 0);
		send_query(0, -1);
		send_query(-24'sd8388608, -24'sd8388608);
		send_query(24'sd8388607, 24'sd8388607);
		send_query(pos_t'(254 * FRAC_ONE + 255), pos_t'(254 * FRAC_ONE + 255));
		send_query(pos_t'(255 * FRAC_ONE), 0);
		send_query(0, pos_t'(255 * FRAC_ONE));
		put_height(STORE_SIZE - 1, 16'sh5a5a);
		put_height(STORE_SIZE - 1, -16'sh5a5b);
		random_items(60);

		run_phase(256, 256, 0, 0, 70);
		run_phase(2, 2, -8388608, -8388608, 70);
		run_phase(511, 300, 1000, -5000, 70);
		run_phase(0, 5, 0, 0, 40);
		run_phase(1, 1, 77, -77, 30);
		run_phase(17, 9, 8388607, 8388607, 40);
		run_phase(3, 200, -123456, 654321, 70);
		run_phase(256, 2, -300, 4095, 70);
		run_phase(2, 256, 8388000, -8388000, 70);
		repeat (4)
			run_phase($urandom_range(2, 256), $urandom_range(2, 256),
				int'($urandom_range(0, 4000)) - 2000, int'($urandom_range(0, 4000)) - 2000, 70);
		drain();

		if (fails == 0)
			$display("heightmap_triangle_height_sampler_core: match");
		else
			$display("heightmap_triangle_height_sampler_core: mismatch");
		$finish;
	end
endmodule

### files.f
+incdir+rtl
rtl/hts_pkg.sv
rtl/hts_front.sv
rtl/hts_queue.sv
rtl/hts_back.sv
rtl/heightmap_triangle_height_sampler_core.sv
bench/heightmap_height_checker.sv
bench/tb_heightmap_triangle_height_sampler_core.sv
